// ===== hw/rtl/grs_pkg.sv =====
// Shared constants and types for the grouped running statistics block.
`timescale 1ns / 1ps

package grs_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int CFG_BITS      = 13;
    localparam int MAX_SET_SIZE  = 4096;
    localparam int MAX_SET_COUNT = 4096;
    localparam int ADDR_BITS     = 3;
    localparam int DATA_BITS     = 32;

    localparam int SET_SUM_BITS  = 29;
    localparam int LOT_SUM_BITS  = 41;
    localparam int LOT_FILL_BITS = 25;

    localparam int Q8_SHIFT      = 8;
    localparam int PERCENT_SCALE = 100;
    localparam int AVG_BITS      = 24;
    localparam int PCT_BITS      = 15;
    localparam int PCT_MAX       = PERCENT_SCALE << Q8_SHIFT;

    localparam int DVD_BITS      = LOT_SUM_BITS - 1 + Q8_SHIFT;
    localparam int DVS_BITS      = LOT_FILL_BITS;
    localparam int QUO_BITS      = 25;

    localparam int QUEUE_DEPTH   = 4;

    localparam logic KIND_SET = 1'b0;
    localparam logic KIND_LOT = 1'b1;

    localparam logic REG_SET_SIZE  = 1'b0;
    localparam logic REG_SET_COUNT = 1'b1;

    typedef struct packed {
        logic [CFG_BITS-1:0] set_size;
        logic [CFG_BITS-1:0] set_count;
    } grs_cfg_t;

    typedef struct packed {
        logic signed [SET_SUM_BITS-1:0]  set_sum;
        logic        [CFG_BITS-1:0]      set_fill;
        logic signed [SAMPLE_BITS-1:0]   set_max;
        logic        [CFG_BITS-1:0]      set_positive;
        logic                            lot_end;
        logic signed [LOT_SUM_BITS-1:0]  lot_sum;
        logic        [LOT_FILL_BITS-1:0] lot_fill;
        logic        [LOT_FILL_BITS-1:0] lot_negative;
        logic signed [SAMPLE_BITS-1:0]   lot_min;
    } grs_entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } grs_div_status_t;

endpackage

// ===== hw/rtl/grouped_running_statistics.sv =====
// Top level of the grouped running statistics block with its register port.
`timescale 1ns / 1ps

// Samples are accepted one per cycle as long as the four-entry queue of
// set-end records has room; samples that do not end a set cost nothing more.
// Each report (set or lot) is paced in the back end by the shared
// one-bit-per-cycle divider, which runs 25 steps for the average and 25
// for the percentage, plus the load and handoff states. A set end that
// also ends the lot yields two reports. There is no clearing pass after
// reset. Registers: set_size at address 0, set_count at address 4. Of
// a write only bits 12:0 are kept; zero reads back as 1, above 4096 as 4096.

module grouped_running_statistics (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [grs_pkg::ADDR_BITS-1:0]          paddr,
    input  logic [grs_pkg::DATA_BITS-1:0]          pwdata,
    output logic [grs_pkg::DATA_BITS-1:0]          prdata,
    output logic                                   pready,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [grs_pkg::SAMPLE_BITS-1:0] s_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_report_kind,
    output logic signed [grs_pkg::AVG_BITS-1:0]    m_average_q8,
    output logic signed [grs_pkg::SAMPLE_BITS-1:0] m_extreme_value,
    output logic        [grs_pkg::PCT_BITS-1:0]    m_percent_q8,
    output logic                                   m_last_result
);
    import grs_pkg::*;

    logic [CFG_BITS-1:0] set_size_reg;
    logic [CFG_BITS-1:0] set_count_reg;
    logic                cfg_wr;
    logic                reg_index;
    grs_cfg_t            cfg;

    grs_entry_t q_push_data;
    grs_entry_t q_pop_data;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;

    function automatic logic [CFG_BITS-1:0] clamp_cfg(input logic [DATA_BITS-1:0] v,
                                                      input logic [CFG_BITS-1:0] maxv);
        logic [CFG_BITS-1:0] t;
        t = v[CFG_BITS-1:0];
        if (t == '0) begin
            t = CFG_BITS'(1);
        end else if (t > maxv) begin
            t = maxv;
        end
        return t;
    endfunction

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign reg_index = paddr[2];

    always_comb begin
        case (reg_index)
            REG_SET_SIZE:  prdata = DATA_BITS'(set_size_reg);
            REG_SET_COUNT: prdata = DATA_BITS'(set_count_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_size_reg  <= CFG_BITS'(1);
            set_count_reg <= CFG_BITS'(1);
        end else if (cfg_wr) begin
            case (reg_index)
                REG_SET_SIZE:  set_size_reg  <= clamp_cfg(pwdata, CFG_BITS'(MAX_SET_SIZE));
                REG_SET_COUNT: set_count_reg <= clamp_cfg(pwdata, CFG_BITS'(MAX_SET_COUNT));
                default: begin
                end
            endcase
        end
    end

    assign cfg.set_size  = set_size_reg;
    assign cfg.set_count = set_count_reg;

    grs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_sample (s_sample),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    grs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_pop_data)
    );

    grs_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_data          (q_pop_data),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_report_kind   (m_report_kind),
        .m_average_q8    (m_average_q8),
        .m_extreme_value (m_extreme_value),
        .m_percent_q8    (m_percent_q8),
        .m_last_result   (m_last_result)
    );

`ifndef SYNTH
    a_lot_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_report_kind == KIND_LOT) |-> m_last_result)
        else $error("lot report not marked as last word");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_percent_q8 <= PCT_BITS'(PCT_MAX)))
        else $error("percentage out of range");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_cfg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> (set_size_reg != '0 && set_count_reg != '0 &&
                    set_size_reg <= CFG_BITS'(MAX_SET_SIZE) &&
                    set_count_reg <= CFG_BITS'(MAX_SET_COUNT)))
        else $error("configuration register out of range");
`endif

endmodule

// ===== hw/rtl/grs_queue.sv =====
// Short queue of set-end records between the front and the back.
`timescale 1ns / 1ps

module grs_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  grs_pkg::grs_entry_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               pop_valid,
    output grs_pkg::grs_entry_t pop_data
);
    import grs_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    grs_entry_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_reg, wr_next;
    logic [PTR_BITS-1:0] rd_reg, rd_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push) begin
            wr_next = (wr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_next = (rd_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/grs_divider.sv =====
// Radix-2 restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module grs_divider (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [grs_pkg::DVD_BITS-1:0]    dividend,
    input  logic [grs_pkg::DVS_BITS-1:0]    divisor,
    output grs_pkg::grs_div_status_t        status,
    output logic [grs_pkg::QUO_BITS-1:0]    quotient
);
    import grs_pkg::*;

    localparam int STEP_BITS = $clog2(QUO_BITS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [DVS_BITS-1:0]  rem_reg;
    logic [QUO_BITS-1:0]  shift_reg;
    logic [DVS_BITS-1:0]  dvs_reg;
    logic [DVS_BITS:0]    trial;
    logic [DVS_BITS:0]    diff;
    logic                 fits;
    logic [DVS_BITS-1:0]  rem_next;

    // The quotient is known to fit in QUO_BITS, so the upper dividend bits
    // start out below the divisor.
    assign trial    = {rem_reg, shift_reg[QUO_BITS-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign fits     = (trial >= {1'b0, dvs_reg});
    assign rem_next = fits ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_BITS'(QUO_BITS);
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_BITS'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= DVS_BITS'(dividend[DVD_BITS-1:QUO_BITS]);
            shift_reg <= dividend[QUO_BITS-1:0];
            dvs_reg   <= divisor;
        end else if (busy_reg) begin
            rem_reg   <= rem_next;
            shift_reg <= {shift_reg[QUO_BITS-2:0], fits};
        end
    end

endmodule

// ===== hw/rtl/grs_front.sv =====
// Front end: accepts samples, keeps the set and lot accumulators, queues set ends.
`timescale 1ns / 1ps

module grs_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  grs_pkg::grs_cfg_t                      cfg,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [grs_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                                   q_full,
    output logic                                   q_push,
    output grs_pkg::grs_entry_t                    q_data
);
    import grs_pkg::*;

    logic signed [SET_SUM_BITS-1:0]  set_sum_reg, set_sum_next;
    logic        [CFG_BITS-1:0]      set_fill_reg, set_fill_next;
    logic signed [SAMPLE_BITS-1:0]   set_max_reg, set_max_next;
    logic signed [SAMPLE_BITS-1:0]   set_min_reg, set_min_next;
    logic        [CFG_BITS-1:0]      set_positive_reg, set_positive_next;
    logic signed [LOT_SUM_BITS-1:0]  lot_sum_reg, lot_sum_next;
    logic        [LOT_FILL_BITS-1:0] lot_fill_reg, lot_fill_next;
    logic        [LOT_FILL_BITS-1:0] lot_negative_reg, lot_negative_next;
    logic signed [SAMPLE_BITS-1:0]   lot_min_reg, lot_min_next;
    logic        [CFG_BITS-1:0]      sets_done_reg, sets_done_next;

    logic accept;
    logic first;
    logic set_end;
    logic lot_end;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign first   = (set_fill_reg == '0);

    always_comb begin
        set_max_next = (first || s_sample > set_max_reg) ? s_sample : set_max_reg;
        set_min_next = (first || s_sample < set_min_reg) ? s_sample : set_min_reg;
        set_positive_next = set_positive_reg + CFG_BITS'(s_sample > 0);
        lot_negative_next = lot_negative_reg + LOT_FILL_BITS'(s_sample < 0);
        set_sum_next  = set_sum_reg + SET_SUM_BITS'(s_sample);
        lot_sum_next  = lot_sum_reg + LOT_SUM_BITS'(s_sample);
        set_fill_next = set_fill_reg + 1'b1;
        lot_fill_next = lot_fill_reg + 1'b1;
        lot_min_next  = (sets_done_reg == '0 || set_min_next < lot_min_reg)
                        ? set_min_next : lot_min_reg;
        sets_done_next = sets_done_reg + 1'b1;
        set_end = (set_fill_next >= cfg.set_size);
        lot_end = set_end && (sets_done_next >= cfg.set_count);
    end

    assign q_push = accept && set_end;

    always_comb begin
        q_data.set_sum      = set_sum_next;
        q_data.set_fill     = set_fill_next;
        q_data.set_max      = set_max_next;
        q_data.set_positive = set_positive_next;
        q_data.lot_end      = lot_end;
        q_data.lot_sum      = lot_sum_next;
        q_data.lot_fill     = lot_fill_next;
        q_data.lot_negative = lot_negative_next;
        q_data.lot_min      = lot_min_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_sum_reg      <= '0;
            set_fill_reg     <= '0;
            set_max_reg      <= '0;
            set_min_reg      <= '0;
            set_positive_reg <= '0;
            lot_sum_reg      <= '0;
            lot_fill_reg     <= '0;
            lot_negative_reg <= '0;
            lot_min_reg      <= '0;
            sets_done_reg    <= '0;
        end else if (accept) begin
            if (set_end) begin
                set_sum_reg      <= '0;
                set_fill_reg     <= '0;
                set_max_reg      <= '0;
                set_min_reg      <= '0;
                set_positive_reg <= '0;
            end else begin
                set_sum_reg      <= set_sum_next;
                set_fill_reg     <= set_fill_next;
                set_max_reg      <= set_max_next;
                set_min_reg      <= set_min_next;
                set_positive_reg <= set_positive_next;
            end
            if (lot_end) begin
                lot_sum_reg      <= '0;
                lot_fill_reg     <= '0;
                lot_negative_reg <= '0;
                lot_min_reg      <= '0;
                sets_done_reg    <= '0;
            end else begin
                lot_sum_reg      <= lot_sum_next;
                lot_fill_reg     <= lot_fill_next;
                lot_negative_reg <= lot_negative_next;
                if (set_end) begin
                    lot_min_reg   <= lot_min_next;
                    sets_done_reg <= sets_done_next;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/grs_back.sv =====
// Back end: turns queued set ends into set and lot reports using a shared divider.
`timescale 1ns / 1ps

module grs_back (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   q_valid,
    input  grs_pkg::grs_entry_t                    q_data,
    output logic                                   q_pop,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_report_kind,
    output logic signed [grs_pkg::AVG_BITS-1:0]    m_average_q8,
    output logic signed [grs_pkg::SAMPLE_BITS-1:0] m_extreme_value,
    output logic        [grs_pkg::PCT_BITS-1:0]    m_percent_q8,
    output logic                                   m_last_result
);
    import grs_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOAD,
        B_AVG,
        B_PCT,
        B_HOLD
    } back_state_t;

    back_state_t state_reg;

    grs_entry_t                      entry_reg;
    logic                            phase_reg;
    logic                            neg_reg;
    logic [DVD_BITS-1:0]             pct_dvd_reg;
    logic                            m_valid_reg;
    logic                            m_kind_reg;
    logic [AVG_BITS-1:0]             m_avg_reg;
    logic signed [SAMPLE_BITS-1:0]   m_ext_reg;
    logic [PCT_BITS-1:0]             m_pct_reg;
    logic                            m_last_reg;

    logic signed [LOT_SUM_BITS-1:0]   job_sum;
    logic        [LOT_FILL_BITS-1:0]  job_cnt;
    logic        [LOT_FILL_BITS-1:0]  job_part;
    logic signed [SAMPLE_BITS-1:0]    job_ext;
    logic        [LOT_SUM_BITS-1:0]   sum_mag;
    logic        [DVD_BITS-1:0]       avg_dvd;
    logic [LOT_FILL_BITS+PCT_BITS-1:0] pct_prod;
    logic                             more;

    logic                   div_start;
    logic [DVD_BITS-1:0]    div_dividend;
    grs_div_status_t        div_status;
    logic [QUO_BITS-1:0]    div_quotient;
    logic [AVG_BITS-1:0]    q_avg;

    always_comb begin
        if (phase_reg == KIND_LOT) begin
            job_sum  = entry_reg.lot_sum;
            job_cnt  = entry_reg.lot_fill;
            job_part = entry_reg.lot_negative;
            job_ext  = entry_reg.lot_min;
        end else begin
            job_sum  = {{(LOT_SUM_BITS-SET_SUM_BITS){entry_reg.set_sum[SET_SUM_BITS-1]}},
                        entry_reg.set_sum};
            job_cnt  = LOT_FILL_BITS'(entry_reg.set_fill);
            job_part = LOT_FILL_BITS'(entry_reg.set_positive);
            job_ext  = entry_reg.set_max;
        end
        sum_mag  = job_sum[LOT_SUM_BITS-1] ? -job_sum : job_sum;
        avg_dvd  = {sum_mag[LOT_SUM_BITS-2:0], {Q8_SHIFT{1'b0}}};
        pct_prod = job_part * PCT_BITS'(PCT_MAX);
        more     = (phase_reg == KIND_SET) && entry_reg.lot_end;
    end

    assign q_pop        = (state_reg == B_IDLE) && q_valid;
    assign div_start    = (state_reg == B_LOAD) || (state_reg == B_AVG && div_status.done);
    assign div_dividend = (state_reg == B_LOAD) ? avg_dvd : pct_dvd_reg;
    assign q_avg        = div_quotient[AVG_BITS-1:0];

    grs_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (job_cnt),
        .status   (div_status),
        .quotient (div_quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                B_IDLE: begin
                    if (q_valid) begin
                        entry_reg <= q_data;
                        phase_reg <= KIND_SET;
                        state_reg <= B_LOAD;
                    end
                end
                B_LOAD: begin
                    neg_reg     <= job_sum[LOT_SUM_BITS-1];
                    pct_dvd_reg <= DVD_BITS'(pct_prod);
                    m_kind_reg  <= phase_reg;
                    m_ext_reg   <= job_ext;
                    state_reg   <= B_AVG;
                end
                B_AVG: begin
                    if (div_status.done) begin
                        m_avg_reg <= neg_reg ? (~q_avg + 1'b1) : q_avg;
                        state_reg <= B_PCT;
                    end
                end
                B_PCT: begin
                    if (div_status.done) begin
                        m_pct_reg   <= div_quotient[PCT_BITS-1:0];
                        m_last_reg  <= !more;
                        m_valid_reg <= 1'b1;
                        state_reg   <= B_HOLD;
                    end
                end
                B_HOLD: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (more) begin
                            phase_reg <= KIND_LOT;
                            state_reg <= B_LOAD;
                        end else begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_report_kind   = m_kind_reg;
    assign m_average_q8    = m_avg_reg;
    assign m_extreme_value = m_ext_reg;
    assign m_percent_q8    = m_pct_reg;
    assign m_last_result   = m_last_reg;

endmodule
